// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cma_pkg.sv -----
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants and types of the centered moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int MAX_RADIUS  = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 4;
    localparam int DEPTH       = 2 * MAX_RADIUS + 1;
    localparam int RAD_BITS    = $clog2(MAX_RADIUS + 1);
    localparam int IDX_BITS    = RAD_BITS + 1;
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int DIV_BITS    = $clog2(DEPTH + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(DEPTH + 1);
    localparam int STEP_BITS   = $clog2(SUM_BITS);
    localparam int AVG_BITS    = SAMPLE_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [AVG_BITS-1:0] NEG_ONE = '1;

    // one accepted sample, classified for the back end
    typedef struct packed {
        logic                has_avg;
        logic                neg_first;
        logic [RAD_BITS-1:0] extra;
        logic                last_of_array;
        logic [SUM_BITS-1:0] sum;
        logic [DIV_BITS-1:0] divisor;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/cma_front.sv -----
// ----------------------------------------------------------------------------
// cma_front
// Accepts samples, keeps the sample window and running sum, classifies.
// ----------------------------------------------------------------------------
module cma_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [cma_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                           array_end,
    input  logic                           cfg_we,
    input  logic [cma_pkg::CFG_BITS-1:0]   cfg_data,
    input  cma_pkg::q_status_t             q_status,
    output logic                           cmd_push,
    output cma_pkg::cmd_t                  cmd
);
    import cma_pkg::*;

    logic [SAMPLE_BITS-1:0] store_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] store_next [DEPTH];
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [CNT_BITS-1:0]    seen_reg, seen_next;
    logic [RAD_BITS-1:0]    radius_reg, radius_next;

    logic                   accept;
    logic [IDX_BITS-1:0]    span;
    logic [SAMPLE_BITS-1:0] leaving;
    logic [SUM_BITS:0]      sum_wide;
    logic                   below_k;
    logic                   past_span;
    logic [CNT_BITS-1:0]    tail_cnt;

    assign full      = q_status.full;
    assign accept    = push && !q_status.full;
    assign span      = {radius_reg, 1'b0};
    assign leaving   = store_reg[span];
    assign sum_wide  = {1'b0, sum_reg} + (SUM_BITS + 1)'(sample)
                       - (SUM_BITS + 1)'(leaving);
    assign below_k   = seen_reg < CNT_BITS'(radius_reg);
    assign past_span = seen_reg >= CNT_BITS'(span);
    assign tail_cnt  = seen_reg - CNT_BITS'(radius_reg) + CNT_BITS'(1);

    always_comb
    begin
        cmd.has_avg       = past_span;
        cmd.neg_first     = below_k;
        cmd.last_of_array = array_end;
        cmd.sum           = sum_wide[SUM_BITS-1:0];
        cmd.divisor       = DIV_BITS'(span) + DIV_BITS'(1);
        if (!array_end || below_k)
        begin
            cmd.extra = '0;
        end
        else if (past_span)
        begin
            cmd.extra = radius_reg;
        end
        else
        begin
            cmd.extra = tail_cnt[RAD_BITS-1:0];
        end
        cmd_push = accept && (below_k || past_span || array_end);
    end

    always_comb
    begin
        store_next  = store_reg;
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        radius_next = radius_reg;
        if (cfg_we)
        begin
            // new radius drops the array in progress
            if (int'(cfg_data) > MAX_RADIUS)
            begin
                radius_next = RAD_BITS'(MAX_RADIUS);
            end
            else
            begin
                radius_next = RAD_BITS'(cfg_data);
            end
            for (int n = 0; n < DEPTH; n++)
            begin
                store_next[n] = '0;
            end
            sum_next  = '0;
            seen_next = '0;
        end
        else if (accept)
        begin
            if (array_end)
            begin
                for (int n = 0; n < DEPTH; n++)
                begin
                    store_next[n] = '0;
                end
                sum_next  = '0;
                seen_next = '0;
            end
            else
            begin
                store_next[0] = sample;
                for (int n = 1; n < DEPTH; n++)
                begin
                    store_next[n] = store_reg[n-1];
                end
                sum_next = sum_wide[SUM_BITS-1:0];
                if (seen_reg != CNT_BITS'(DEPTH))
                begin
                    seen_next = seen_reg + CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < DEPTH; n++)
            begin
                store_reg[n] <= '0;
            end
            sum_reg    <= '0;
            seen_reg   <= '0;
            radius_reg <= RAD_BITS'(1);
        end
        else
        begin
            store_reg  <= store_next;
            sum_reg    <= sum_next;
            seen_reg   <= seen_next;
            radius_reg <= radius_next;
        end
    end

endmodule

// ----- rtl/cma_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// cma_cmd_queue
// Short queue of classified samples between the front and back ends.
// ----------------------------------------------------------------------------
module cma_cmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  cma_pkg::cmd_t      wr_cmd,
    input  logic               rd_en,
    output cma_pkg::cmd_t      rd_cmd,
    output cma_pkg::q_status_t status
);
    import cma_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign status.full  = count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign rd_cmd       = entry_reg[rd_ptr_reg];
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (QPTR_BITS + 1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (QPTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/cma_back.sv -----
// ----------------------------------------------------------------------------
// cma_back
// Runs the bit-serial divider and emits the results of each command.
// ----------------------------------------------------------------------------
module cma_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cma_pkg::q_status_t           q_status,
    input  cma_pkg::cmd_t                head_cmd,
    output logic                         q_pop,
    output logic                         idle,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [cma_pkg::AVG_BITS-1:0] average,
    output logic                         run_last,
    output logic                         array_done
);
    import cma_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic                 has_avg_reg, has_avg_next;
    logic                 head_reg, head_next;
    logic [RAD_BITS-1:0]  extra_reg, extra_next;
    logic                 end_reg, end_next;
    logic [DIV_BITS-1:0]  divisor_reg, divisor_next;
    logic [DIV_BITS-1:0]  rem_reg, rem_next;
    logic [SUM_BITS-1:0]  quo_reg, quo_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [AVG_BITS-1:0]  avg_reg, avg_next;
    logic                 run_last_reg, run_last_next;
    logic                 done_reg, done_next;

    logic [DIV_BITS:0]    trial;
    logic                 fits;
    logic                 slot_free;
    logic                 last;

    assign trial     = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits      = trial >= {1'b0, divisor_reg};
    assign slot_free = !out_valid_reg || pop;

    assign empty      = !out_valid_reg;
    assign average    = $signed(avg_reg);
    assign run_last   = run_last_reg;
    assign array_done = done_reg;
    assign idle       = (state_reg == ST_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        has_avg_next   = has_avg_reg;
        head_next      = head_reg;
        extra_next     = extra_reg;
        end_next       = end_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        avg_next       = avg_reg;
        run_last_next  = run_last_reg;
        done_next      = done_reg;
        q_pop          = 1'b0;
        last           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop        = 1'b1;
                    has_avg_next = head_cmd.has_avg;
                    head_next    = head_cmd.has_avg || head_cmd.neg_first;
                    extra_next   = head_cmd.extra;
                    end_next     = head_cmd.last_of_array;
                    divisor_next = head_cmd.divisor;
                    rem_next     = '0;
                    quo_next     = head_cmd.sum;
                    step_next    = STEP_BITS'(SUM_BITS - 1);
                    state_next   = head_cmd.has_avg ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, restoring
                if (fits)
                begin
                    rem_next = DIV_BITS'(trial - {1'b0, divisor_reg});
                end
                else
                begin
                    rem_next = trial[DIV_BITS-1:0];
                end
                quo_next = {quo_reg[SUM_BITS-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg - STEP_BITS'(1);
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (head_reg)
                    begin
                        avg_next  = has_avg_reg ? {1'b0, quo_reg[SAMPLE_BITS-1:0]} : NEG_ONE;
                        head_next = 1'b0;
                        last      = extra_reg == '0;
                    end
                    else
                    begin
                        avg_next   = NEG_ONE;
                        extra_next = extra_reg - RAD_BITS'(1);
                        last       = extra_reg == RAD_BITS'(1);
                    end
                    run_last_next = last;
                    done_next     = last && end_reg;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        has_avg_reg  <= has_avg_next;
        head_reg     <= head_next;
        extra_reg    <= extra_next;
        end_reg      <= end_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        avg_reg      <= avg_next;
        run_last_reg <= run_last_next;
        done_reg     <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/centered_moving_average.sv -----
// ----------------------------------------------------------------------------
// centered_moving_average
// Truncated mean of the 2k+1 samples centered on each array index.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a sample and its array_end flag transfer
// when push is high and full is low. Results come out of a queue read port:
// average, run_last and array_done are valid while empty is low and transfer
// when pop is high. average is -1 where the window does not fit the array.
// The radius register is written over cfg_valid/cfg_ready; ready is high only
// when no work is in flight. A write also drops the array in progress.
// A result passes through the command queue, the back-end registers and
// the output registers; a mean also goes through the bit-serial divider
// (one bit per cycle over the 21-bit window sum). Samples transfer one per
// cycle while the 4-entry command queue has room; samples that give no
// result take no entry. The back end returns to idle after the results of
// one sample, before it takes the next; the -1 results of one sample leave
// one per cycle while pop is high. Reset sets radius to 1 and clears the
// window, sum and sample count. When the receiver stalls, the result holds
// on the ports, the back end waits, the queue fills and full rises.
// ----------------------------------------------------------------------------
module centered_moving_average (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [cma_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                            array_end,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [cma_pkg::AVG_BITS-1:0] average,
    output logic                            run_last,
    output logic                            array_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cma_pkg::CFG_BITS-1:0]    radius
);
    import cma_pkg::*;

    q_status_t q_status;
    cmd_t      wr_cmd;
    cmd_t      head_cmd;
    logic      cmd_push;
    logic      q_pop;
    logic      back_idle;
    logic      cfg_we;

    assign cfg_ready = q_status.empty && back_idle;
    assign cfg_we    = cfg_valid && cfg_ready;

    cma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .array_end (array_end),
        .cfg_we    (cfg_we),
        .cfg_data  (radius),
        .q_status  (q_status),
        .cmd_push  (cmd_push),
        .cmd       (wr_cmd)
    );

    cma_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (wr_cmd),
        .rd_en  (q_pop),
        .rd_cmd (head_cmd),
        .status (q_status)
    );

    cma_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_cmd   (head_cmd),
        .q_pop      (q_pop),
        .idle       (back_idle),
        .empty      (empty),
        .pop        (pop),
        .average    (average),
        .run_last   (run_last),
        .array_done (array_done)
    );

endmodule

// ----- rtl/cma_checker.sv -----
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks of the centered moving average, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cma_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            empty,
    input logic                            pop,
    input logic signed [cma_pkg::AVG_BITS-1:0] average,
    input logic                            run_last,
    input logic                            array_done,
    input logic                            cfg_ready
);
    import cma_pkg::*;

    // the end-of-array result always closes its item
    `ASSERT_IMPL(a_done_is_last, !empty && array_done, run_last, "array_done without run_last")

    // a mean never exceeds the sample range, and the only negative is -1
    `ASSERT_IMPL(a_avg_range, !empty, !average[AVG_BITS-1] || average == NEG_ONE, "bad average")

    // the radius is open for writing only with nothing waiting at the output
    `ASSERT_IMPL(a_cfg_idle, cfg_ready, empty, "cfg_ready while a result waits")

    // a stalled result holds
    `ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(average) && $stable(run_last), "result changed under stall")

endmodule

bind centered_moving_average cma_checker u_cma_checker (.*);

// ----- sim/cma_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_tb_checker
// Watches the sample, result and radius channels of the centered moving
// average block. It keeps its own window, sum and sample count, predicts the
// results of every accepted sample, and compares each popped result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module cma_tb_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic [cma_pkg::SAMPLE_BITS-1:0]      sample,
    input  logic                                 array_end,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic signed [cma_pkg::AVG_BITS-1:0]  average,
    input  logic                                 run_last,
    input  logic                                 array_done,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [cma_pkg::CFG_BITS-1:0]         radius,
    output int                                   errors,
    output int                                   pending,
    output int                                   checked
);
    import cma_pkg::*;

    typedef struct packed {
        logic signed [AVG_BITS-1:0] average;
        logic                       run_last;
        logic                       array_done;
    } avg_result_t;

    logic [SAMPLE_BITS-1:0] window [DEPTH];
    logic [SUM_BITS-1:0]    window_total;
    int unsigned            filled;
    int unsigned            window_radius;
    avg_result_t            expected_averages [$];
    int                     error_count   = 0;
    int                     compare_count = 0;

    function automatic void clear_window();
        for (int j = 0; j < DEPTH; j++)
            window[j] = '0;
        window_total = '0;
        filled       = 0;
    endfunction

    function automatic void predict_averages(input logic [SAMPLE_BITS-1:0] s,
                                             input logic last);
        int unsigned         span;
        int unsigned         idx;
        int unsigned         extra;
        logic [SUM_BITS-1:0] leaving;
        avg_result_t         batch [$];
        avg_result_t         r;
        span    = 2 * window_radius;
        idx     = filled;
        leaving = window[span];
        // shift in the new sample, keep the sum over the newest 2k+1 entries
        for (int j = DEPTH - 1; j > 0; j--)
            window[j] = window[j-1];
        window[0]    = s;
        window_total = window_total + SUM_BITS'(s) - leaving;
        r = '0;
        if (idx < window_radius)
        begin
            r.average = NEG_ONE;
            batch.push_back(r);
        end
        else if (idx >= span)
        begin
            r.average = AVG_BITS'(window_total / SUM_BITS'(span + 1));
            batch.push_back(r);
        end
        if (last)
        begin
            extra = 0;
            if (idx >= span)
                extra = window_radius;
            else if (idx >= window_radius)
                extra = idx - window_radius + 1;
            r.average = NEG_ONE;
            repeat (extra) batch.push_back(r);
            clear_window();
        end
        else if (filled < DEPTH)
        begin
            filled++;
        end
        if (batch.size() > 0)
        begin
            r            = batch[batch.size() - 1];
            r.run_last   = 1'b1;
            r.array_done = last;
            batch[batch.size() - 1] = r;
        end
        foreach (batch[j])
            expected_averages.push_back(batch[j]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_result_t want;
        if (!rst_n)
        begin
            window_radius = 1;
            clear_window();
            expected_averages.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_radius = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
                clear_window();
            end
            if (push && !full)
                predict_averages(sample, array_end);
            if (pop && !empty)
            begin
                if (expected_averages.size() == 0)
                begin
                    $error("result with no prediction waiting: average=%0d", average);
                    error_count++;
                end
                else
                begin
                    want = expected_averages.pop_front();
                    compare_count++;
                    if (average !== want.average)
                    begin
                        $error("average: expected %0d, actual %0d", want.average, average);
                        error_count++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b", want.run_last, run_last);
                        error_count++;
                    end
                    if (array_done !== want.array_done)
                    begin
                        $error("array_done: expected %0b, actual %0b",
                               want.array_done, array_done);
                        error_count++;
                    end
                end
            end
        end
        errors  <= error_count;
        pending <= expected_averages.size();
        checked <= compare_count;
    end

endmodule

// ----- sim/centered_moving_average_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average_tb
// Drives arrays of samples into the centered moving average block under a
// range of radius settings, with random gaps on the sample side and random
// stalls on the result side. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module centered_moving_average_tb;
    import cma_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 480;
    localparam int PHASE_ITEMS  = 60;
    localparam int SETTLE       = 40;
    localparam int MAX_GAP      = 16;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        push      = 1'b0;
    logic                        full;
    logic [SAMPLE_BITS-1:0]      sample    = '0;
    logic                        array_end = 1'b0;
    logic                        empty;
    logic                        pop       = 1'b0;
    logic signed [AVG_BITS-1:0]  average;
    logic                        run_last;
    logic                        array_done;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_BITS-1:0]         radius    = '0;

    int errors;
    int pending;
    int checked;
    int cycle_count = 0;
    int n_items     = 0;
    int n_settings  = 0;
    bit push_fast   = 1'b0;
    bit pop_fast    = 1'b0;

    always #4 clk = ~clk;

    centered_moving_average dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .array_end  (array_end),
        .empty      (empty),
        .pop        (pop),
        .average    (average),
        .run_last   (run_last),
        .array_done (array_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .radius     (radius)
    );

    cma_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .array_end  (array_end),
        .empty      (empty),
        .pop        (pop),
        .average    (average),
        .run_last   (run_last),
        .array_done (array_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .radius     (radius),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Push stays high after a transfer; the next call either keeps it high
    // for a back-to-back transfer or drops it for a gap.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
        int gap;
        gap = push_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        sample    <= s;
        array_end <= last;
        do @(posedge clk); while (full);
        n_items++;
    endtask

    // Wait until every predicted result is out and the back end has drained.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_radius(input logic [CFG_BITS-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        radius    <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Result side: a fresh stall for every result, with stall-free stretches.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                pop_fast = !pop_fast;
            stall = pop_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        int                     fixed_radii [9];
        int                     sent_random;
        int                     phase;
        int                     phase_items;
        int                     k;
        int                     len;
        int                     kind;
        bit                     broken;
        logic [SAMPLE_BITS-1:0] s;
        logic                   last;

        fixed_radii = '{0, 15, 1, 10, 5, 15, 2, 0, 3};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset radius written back, full-scale and zero samples
        write_radius(4'd1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        // short array: ends before a full window exists
        send_sample(16'h0005, 1'b0);
        send_sample(16'h0007, 1'b1);
        // zero radius: each sample is its own mean
        write_radius(4'd0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h1234, 1'b1);
        // full-scale window, then an array left open for the next write to drop
        write_radius(4'd2);
        repeat (4) send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h0001, 1'b0);
        // widest radius with a short array
        write_radius(4'd15);
        send_sample(16'hABCD, 1'b0);
        send_sample(16'h5432, 1'b0);
        send_sample(16'h0001, 1'b1);

        sent_random = 0;
        phase       = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            if (phase < 9)
                k = fixed_radii[phase];
            else if ($urandom_range(0, 3) == 0)
                k = $urandom_range(0, 15);
            else
                k = $urandom_range(0, 4);
            write_radius(CFG_BITS'(k));
            phase++;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS && sent_random < RANDOM_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, 2 * k + 1);
                else
                    len = $urandom_range(2 * k + 1, 2 * k + 12);
                kind      = $urandom_range(0, 7);
                push_fast = ($urandom_range(0, 3) == 0);
                // a broken array misses its end flag and runs into the next one
                broken    = ($urandom_range(0, 7) == 0);
                for (int j = 0; j < len; j++)
                begin
                    case (kind)
                        0:       s = '1;
                        1:       s = '0;
                        2:       s = $urandom_range(0, 1) ? '1 : '0;
                        default: s = SAMPLE_BITS'($urandom_range(0, 65535));
                    endcase
                    last = (j == len - 1) && !broken;
                    send_sample(s, last);
                    sent_random++;
                    phase_items++;
                end
            end
        end
        push_fast = 1'b0;

        drain();
        $display("%0d samples sent over %0d radius settings, %0d results compared",
                 n_items, n_settings, checked);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
